FILE: design/cfm_pkg.sv
package cfm_pkg;

	// Kind of input item, carried on s_tuser.
	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_CLOCK  = 1'b1
	} op_t;

	// Tape drive level codes.
	localparam logic [1:0] LVL_NEG     = 2'd0;
	localparam logic [1:0] LVL_SILENCE = 2'd1;
	localparam logic [1:0] LVL_POS     = 2'd2;

	// Edge gap thresholds, in sample ticks.
	localparam logic [7:0] PHASE_WIDE_GAP = 8'd13;
	localparam logic [2:0] PHASE_RXC_TAP  = 3'd2;
	localparam logic [7:0] KC_SHORT_GAP   = 8'd12;
	localparam logic [7:0] KC_IDLE_GAP    = 8'd32;

	// Register word addresses on the configuration port.
	localparam int         CFG_AW         = 3;
	localparam logic [CFG_AW-1:0] REG_PHASE_MODE = 3'd0;

	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 16;

	// One result item, lowest field in the lowest bit.
	typedef struct packed {
		logic [1:0] tape_level;
		logic       tape_valid;
		logic       txc_value;
		logic       txc_valid;
		logic       rxc_value;
		logic       rxc_valid;
		logic       rxd_value;
		logic       rxd_valid;
	} res_t;

	localparam int RES_W = $bits(res_t);

endpackage

FILE: design/cassette_fsk_modem.sv
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tuser = op, s_tdata = tape and USART line bits
// m_*       out  m_tvalid/m_tready  m_tdata = USART drive and tape drive result
// APB       in   psel/penable       phase_mode at byte address 0
//
// Each accepted transfer yields exactly one result transfer. All the work for an
// item (edge detection, gap counting, wave generation) is a single pass of logic
// from the accepted item and the modem state into the result register, so if the
// output is free, items can be taken every cycle; a result appears the next cycle.
// s_tready is high whenever the result register is empty or is being emptied in
// the same cycle, so a stalled output holds the result and blocks only new input.
// Reset (asynchronous, active low) clears the counters and selects Kansas City
// mode; the held save bit and the decoded receive bit come out of reset at one.
module cassette_fsk_modem (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input stream.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [0] op
	input  logic                          s_tuser,
	// [0] tape_bit, [1] clock_level, [2] dtr_line, [3] rts_line, [4] txd_line
	input  logic [cfm_pkg::IN_DATA_W-1:0] s_tdata,
	// Output stream.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [0] rxd_valid, [1] rxd_value, [2] rxc_valid, [3] rxc_value, [4] txc_valid,
	// [5] txc_value, [6] tape_valid, [8:7] tape_level
	output logic [cfm_pkg::OUT_DATA_W-1:0] m_tdata,
	// Configuration port.
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cfm_pkg::CFG_AW-1:0]    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	import cfm_pkg::*;

	// Mode register.
	logic phase_mode_q;

	// Modem state.
	logic       last_tape_bit_q;
	logic [7:0] edge_gap_count_q;
	logic [2:0] phase_count_q;
	logic       rx_clock_toggle_q;
	logic [3:0] wave_count_q;
	logic       held_save_bit_q;
	logic       phase_polarity_q;
	logic       decoded_bit_q;

	// Next state and the result of the item presented on the input.
	logic       last_tape_bit_d;
	logic [7:0] edge_gap_count_d;
	logic [2:0] phase_count_d;
	logic       rx_clock_toggle_d;
	logic [3:0] wave_count_d;
	logic       held_save_bit_d;
	logic       phase_polarity_d;
	logic       decoded_bit_d;
	res_t       res_d;

	// Result register.
	res_t res_q;
	logic res_valid_q;

	logic in_accept;
	logic cfg_write;

	// Input fields.
	op_t  op;
	logic tape_bit;
	logic clock_level;
	logic dtr_line;
	logic rts_line;
	logic txd_line;

	// Helpers.
	logic [7:0] gap_inc;
	logic [2:0] phase_inc;
	logic       tape_edge;
	logic       save_bit;
	logic       wave_sel;
	logic       wave_idle;

	assign op          = op_t'(s_tuser);
	assign tape_bit    = s_tdata[0];
	assign clock_level = s_tdata[1];
	assign dtr_line    = s_tdata[2];
	assign rts_line    = s_tdata[3];
	assign txd_line    = s_tdata[4];

	assign s_tready  = !res_valid_q || m_tready;
	assign in_accept = s_tvalid && s_tready;

	assign gap_inc   = edge_gap_count_q + 8'd1;
	assign phase_inc = phase_count_q + 3'd1;
	assign tape_edge = tape_bit != last_tape_bit_q;
	assign wave_idle = wave_count_q == 4'd0;

	// The save bit is sampled from the USART only at the start of each wave
	// cycle; a one records as a fast square wave, a zero as half that rate.
	assign save_bit = wave_idle ? txd_line : held_save_bit_q;
	assign wave_sel = save_bit ? wave_count_q[0] : wave_count_q[1];

	always_comb begin
		last_tape_bit_d   = last_tape_bit_q;
		edge_gap_count_d  = edge_gap_count_q;
		phase_count_d     = phase_count_q;
		rx_clock_toggle_d = rx_clock_toggle_q;
		wave_count_d      = wave_count_q;
		held_save_bit_d   = held_save_bit_q;
		phase_polarity_d  = phase_polarity_q;
		decoded_bit_d     = decoded_bit_q;

		res_d            = '0;
		res_d.tape_level = LVL_SILENCE;

		case (op)
			OP_SAMPLE: begin
				if (phase_mode_q) begin
					if (dtr_line) begin
						// Load idle: restart the bit timing.
						edge_gap_count_d  = '0;
						phase_count_d     = '0;
						rx_clock_toggle_d = 1'b0;
						phase_polarity_d  = 1'b0;
					end else begin
						edge_gap_count_d = gap_inc;
						phase_count_d    = phase_inc;
						if (tape_edge) begin
							last_tape_bit_d = tape_bit;
							// A wide gap marks a change of the recorded bit.
							if (gap_inc > PHASE_WIDE_GAP) begin
								phase_polarity_d = !phase_polarity_q;
							end
							edge_gap_count_d = '0;
							phase_count_d    = '0;
							res_d.rxd_valid  = 1'b1;
							res_d.rxd_value  = phase_polarity_d;
						end
						if (phase_count_d == PHASE_RXC_TAP) begin
							rx_clock_toggle_d = !rx_clock_toggle_q;
							res_d.rxc_valid   = 1'b1;
							res_d.rxc_value   = rx_clock_toggle_d;
						end
					end
				end else begin
					edge_gap_count_d = gap_inc;
					if (dtr_line || gap_inc > KC_IDLE_GAP) begin
						edge_gap_count_d = KC_IDLE_GAP;
						decoded_bit_d    = 1'b1;
					end
					if (tape_edge) begin
						last_tape_bit_d  = tape_bit;
						decoded_bit_d    = edge_gap_count_d < KC_SHORT_GAP;
						edge_gap_count_d = '0;
					end
				end
			end
			OP_CLOCK: begin
				if (phase_mode_q) begin
					if (!rts_line) begin
						res_d.tape_valid = 1'b1;
						res_d.tape_level = (txd_line ^ clock_level) ? LVL_NEG : LVL_POS;
					end
				end else begin
					if (rts_line && wave_idle) begin
						res_d.tape_valid = 1'b1;
						res_d.tape_level = LVL_SILENCE;
						wave_count_d     = '0;
					end else if (clock_level) begin
						held_save_bit_d  = save_bit;
						res_d.tape_valid = 1'b1;
						res_d.tape_level = wave_sel ? LVL_NEG : LVL_POS;
						wave_count_d     = wave_count_q + 4'd1;
					end
					if (clock_level && !dtr_line && wave_idle) begin
						res_d.rxd_valid = 1'b1;
						res_d.rxd_value = decoded_bit_q;
					end
					if (!dtr_line) begin
						res_d.rxc_valid = 1'b1;
						res_d.rxc_value = clock_level;
					end
				end
				if (!rts_line) begin
					res_d.txc_valid = 1'b1;
					res_d.txc_value = clock_level;
				end
			end
			default: begin
				res_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_tape_bit_q   <= 1'b0;
			edge_gap_count_q  <= '0;
			phase_count_q     <= '0;
			rx_clock_toggle_q <= 1'b0;
			wave_count_q      <= '0;
			held_save_bit_q   <= 1'b1;
			phase_polarity_q  <= 1'b0;
			decoded_bit_q     <= 1'b1;
		end else if (in_accept) begin
			last_tape_bit_q   <= last_tape_bit_d;
			edge_gap_count_q  <= edge_gap_count_d;
			phase_count_q     <= phase_count_d;
			rx_clock_toggle_q <= rx_clock_toggle_d;
			wave_count_q      <= wave_count_d;
			held_save_bit_q   <= held_save_bit_d;
			phase_polarity_q  <= phase_polarity_d;
			decoded_bit_q     <= decoded_bit_d;
		end
	end

	// Result register: holds a stalled result, refilled on every accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s_tready) begin
			res_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = {{(OUT_DATA_W - RES_W){1'b0}}, res_q};

	// Configuration port: pready is tied high, so no access waits.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_mode_q <= 1'b0;
		end else if (cfg_write && paddr == REG_PHASE_MODE) begin
			phase_mode_q <= pwdata[0];
		end
	end

	assign prdata = (paddr == REG_PHASE_MODE) ? {31'd0, phase_mode_q} : 32'd0;

	// An accepted item always leaves a result waiting on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> m_tvalid)
		else $error("accepted item produced no result");

	// The tape level code is negative, silence or positive drive, never the spare code.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> res_q.tape_level != 2'd3)
		else $error("undefined tape level code");

	// Value fields read zero when not driven; checked here for the tape, which reads silence, and the receive clock.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res_q.tape_valid |-> res_q.tape_level == LVL_SILENCE)
		else $error("undriven tape level is not silence");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res_q.rxc_valid |-> !res_q.rxc_value)
		else $error("undriven receive clock carries a value");

	// The modem state only moves when an item is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_accept |=> $stable(wave_count_q) && $stable(edge_gap_count_q))
		else $error("modem state changed without an accepted item");

endmodule
